// ===== rtl/sic_pkg.sv =====
// ----------------------------------------------------------------------------
// sic_pkg
// Shared constants for the string isomorphism checker: alphabet size,
// character width, table index width and the epoch tag kept in each entry.
// ----------------------------------------------------------------------------
package sic_pkg;

    localparam int CHAR_W   = 8;
    localparam int ALPHABET = 256;
    localparam int IDX_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;

    // One bit wider than a character, so that the full alphabet size fits.
    localparam logic [CHAR_W:0] ALPHA_LIMIT = (CHAR_W + 1)'(ALPHABET);

    // Each table entry holds an epoch tag above the mapped character. Epoch
    // zero is only ever written by the clearing pass, so it never matches.
    localparam int                  EPOCH_W     = 8;
    localparam int                  WORD_W      = EPOCH_W + CHAR_W;
    localparam logic [EPOCH_W-1:0]  EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0]  EPOCH_MAX   = '1;
    localparam logic [IDX_W-1:0]    LAST_IDX    = IDX_W'(ALPHABET - 1);

endpackage
// ----------------------------------------------------------------------------

// ===== rtl/string_isomorphism_checker.sv =====
// ----------------------------------------------------------------------------
// string_isomorphism_checker
// m_valid rises after a pair marked last passes the check stage and the output register.
// Throughput: one pair per cycle unless m_ready stalls the output, set by the single
// read and write port of each mapping RAM. A pair marked last bumps the epoch tag;
// every 255th string the input stalls for a pass that rewrites all entries.
// Reset (aresetn low, synchronous) empties the pipeline, clears the mismatch
// flag and starts the same clearing pass, during which s_ready is low.
// ----------------------------------------------------------------------------
module string_isomorphism_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [sic_pkg::CHAR_W-1:0] s_src_char,
    input  logic [sic_pkg::CHAR_W-1:0] s_dst_char,
    input  logic                       s_src_present,
    input  logic                       s_dst_present,
    input  logic                       s_last_pair,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_is_isomorphic
);

    // Check stage registers.
    logic                       s1_valid_reg;
    logic [sic_pkg::CHAR_W-1:0] s1_src_reg;
    logic [sic_pkg::CHAR_W-1:0] s1_dst_reg;
    logic                       s1_sp_reg;
    logic                       s1_dp_reg;
    logic                       s1_last_reg;

    // Current epoch and sticky flag. An entry is valid only when its stored
    // epoch equals the current one.
    logic [sic_pkg::EPOCH_W-1:0] epoch_reg, epoch_next;
    logic                        mismatch_reg, mismatch_next;

    // Clearing pass over both tables.
    logic                       clr_busy_reg, clr_busy_next;
    logic [sic_pkg::IDX_W-1:0]  clr_addr_reg, clr_addr_next;

    // Last write of each table, forwarded to the following pair.
    logic                       fw_wen_reg;
    logic [sic_pkg::IDX_W-1:0]  fw_addr_reg;
    logic [sic_pkg::WORD_W-1:0] fw_data_reg;
    logic                       bw_wen_reg;
    logic [sic_pkg::IDX_W-1:0]  bw_addr_reg;
    logic [sic_pkg::WORD_W-1:0] bw_data_reg;

    // Output register.
    logic m_valid_reg, m_valid_next;
    logic m_iso_reg, m_iso_next;

    logic                       adv;
    logic                       item_done;
    logic                       wrap_hold;
    logic [sic_pkg::IDX_W-1:0]  fwd_raddr, bwd_raddr;
    logic [sic_pkg::WORD_W-1:0] fwd_rdata, bwd_rdata;
    logic [sic_pkg::IDX_W-1:0]  src_idx, dst_idx;
    logic                       out_of_range;
    logic                       both_present;
    logic                       check;
    logic [sic_pkg::WORD_W-1:0] fwd_word, bwd_word;
    logic [sic_pkg::CHAR_W-1:0] fwd_map, bwd_map;
    logic                       fwd_set, bwd_set;
    logic                       fwd_we, bwd_we;
    logic                       fwd_bad, bwd_bad;
    logic                       pair_bad;
    logic                       fwd_ram_we, bwd_ram_we;
    logic [sic_pkg::IDX_W-1:0]  fwd_waddr, bwd_waddr;
    logic [sic_pkg::WORD_W-1:0] fwd_wdata, bwd_wdata;

    // The pipeline moves whenever the output register is free or drained.
    assign adv       = !m_valid_reg || m_ready;
    // A last pair that wraps the epoch keeps the check stage empty for the
    // clearing pass that follows it.
    assign wrap_hold = s1_valid_reg && s1_last_reg && (epoch_reg == sic_pkg::EPOCH_MAX);
    assign s_ready   = adv && !clr_busy_reg && !wrap_hold;
    assign item_done = s1_valid_reg && adv;

    // While stalled the RAMs keep reading the address of the held pair.
    assign fwd_raddr = adv ? s_src_char[sic_pkg::IDX_W-1:0] : src_idx;
    assign bwd_raddr = adv ? s_dst_char[sic_pkg::IDX_W-1:0] : dst_idx;

    assign fwd_ram_we = clr_busy_reg || (fwd_we && adv);
    assign bwd_ram_we = clr_busy_reg || (bwd_we && adv);
    assign fwd_waddr  = clr_busy_reg ? clr_addr_reg : src_idx;
    assign bwd_waddr  = clr_busy_reg ? clr_addr_reg : dst_idx;
    assign fwd_wdata  = clr_busy_reg ? '0 : {epoch_reg, s1_dst_reg};
    assign bwd_wdata  = clr_busy_reg ? '0 : {epoch_reg, s1_src_reg};

    sic_map_ram #(
        .ADDR_W(sic_pkg::IDX_W),
        .DATA_W(sic_pkg::WORD_W)
    ) u_fwd_ram (
        .aclk    (aclk),
        .wr_en   (fwd_ram_we),
        .wr_addr (fwd_waddr),
        .wr_data (fwd_wdata),
        .rd_addr (fwd_raddr),
        .rd_data (fwd_rdata)
    );

    sic_map_ram #(
        .ADDR_W(sic_pkg::IDX_W),
        .DATA_W(sic_pkg::WORD_W)
    ) u_bwd_ram (
        .aclk    (aclk),
        .wr_en   (bwd_ram_we),
        .wr_addr (bwd_waddr),
        .wr_data (bwd_wdata),
        .rd_addr (bwd_raddr),
        .rd_data (bwd_rdata)
    );

    assign src_idx = s1_src_reg[sic_pkg::IDX_W-1:0];
    assign dst_idx = s1_dst_reg[sic_pkg::IDX_W-1:0];

    assign out_of_range = ({1'b0, s1_src_reg} >= sic_pkg::ALPHA_LIMIT)
                       || ({1'b0, s1_dst_reg} >= sic_pkg::ALPHA_LIMIT);
    assign both_present = s1_sp_reg && s1_dp_reg;
    assign check        = s1_valid_reg && both_present && !out_of_range;

    // The RAM read was issued in the same cycle as the previous pair's write,
    // so that write is taken from the forwarding register instead.
    assign fwd_word = (fw_wen_reg && (fw_addr_reg == src_idx)) ? fw_data_reg : fwd_rdata;
    assign bwd_word = (bw_wen_reg && (bw_addr_reg == dst_idx)) ? bw_data_reg : bwd_rdata;
    assign fwd_map  = fwd_word[sic_pkg::CHAR_W-1:0];
    assign bwd_map  = bwd_word[sic_pkg::CHAR_W-1:0];
    assign fwd_set  = (fwd_word[sic_pkg::WORD_W-1:sic_pkg::CHAR_W] == epoch_reg);
    assign bwd_set  = (bwd_word[sic_pkg::WORD_W-1:sic_pkg::CHAR_W] == epoch_reg);

    assign fwd_we  = check && !fwd_set;
    assign bwd_we  = check && !bwd_set;
    assign fwd_bad = check && fwd_set && (fwd_map != s1_dst_reg);
    assign bwd_bad = check && bwd_set && (bwd_map != s1_src_reg);

    assign pair_bad = (s1_valid_reg && both_present && out_of_range)
                   || (s1_valid_reg && (s1_sp_reg != s1_dp_reg))
                   || fwd_bad || bwd_bad;

    always_comb begin
        epoch_next    = epoch_reg;
        mismatch_next = mismatch_reg;
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        m_valid_next  = m_valid_reg;
        m_iso_next    = m_iso_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == sic_pkg::LAST_IDX) begin
                clr_busy_next = 1'b0;
            end
        end
        if (item_done) begin
            if (s1_last_reg) begin
                mismatch_next = 1'b0;
                if (epoch_reg == sic_pkg::EPOCH_MAX) begin
                    epoch_next    = sic_pkg::EPOCH_FIRST;
                    clr_busy_next = 1'b1;
                    clr_addr_next = '0;
                end else begin
                    epoch_next = epoch_reg + 1'b1;
                end
            end else begin
                mismatch_next = mismatch_reg || pair_bad;
            end
        end
        if (adv) begin
            m_valid_next = item_done && s1_last_reg;
            m_iso_next   = !(mismatch_reg || pair_bad);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            epoch_reg    <= sic_pkg::EPOCH_FIRST;
            mismatch_reg <= 1'b0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            fw_wen_reg   <= 1'b0;
            bw_wen_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            epoch_reg    <= epoch_next;
            mismatch_reg <= mismatch_next;
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
            m_valid_reg  <= m_valid_next;
            if (adv) begin
                s1_valid_reg <= s_valid && s_ready;
                fw_wen_reg   <= fwd_we;
                bw_wen_reg   <= bwd_we;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_iso_reg <= m_iso_next;
        if (adv) begin
            s1_src_reg  <= s_src_char;
            s1_dst_reg  <= s_dst_char;
            s1_sp_reg   <= s_src_present;
            s1_dp_reg   <= s_dst_present;
            s1_last_reg <= s_last_pair;
            fw_addr_reg <= src_idx;
            fw_data_reg <= {epoch_reg, s1_dst_reg};
            bw_addr_reg <= dst_idx;
            bw_data_reg <= {epoch_reg, s1_src_reg};
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_is_isomorphic = m_iso_reg;

endmodule
// ----------------------------------------------------------------------------

// ===== rtl/sic_map_ram.sv =====
// ----------------------------------------------------------------------------
// sic_map_ram
// Simple dual-port synchronous RAM: one write port and one read port with a
// registered read (read-before-write on the same address).
// ----------------------------------------------------------------------------
module sic_map_ram #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 8
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
// ----------------------------------------------------------------------------

// ===== rtl/sic_checker.sv =====
// ----------------------------------------------------------------------------
// sic_checker
// Port-level checks for the string isomorphism checker: results only follow
// transfers marked last, at most two are outstanding, the input is held while
// a full output is stalled, a stalled result is held, and reset empties the output.
// ----------------------------------------------------------------------------
module sic_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_last_pair,
    input logic m_valid,
    input logic m_ready,
    input logic m_is_isomorphic
);

    logic [2:0] pending_reg, pending_next;
    logic       last_in, result_out;

    assign last_in    = s_valid && s_ready && s_last_pair;
    assign result_out = m_valid && m_ready;

    // Count of last-pair transfers whose result has not been transferred yet.
    always_comb begin
        pending_next = pending_reg;
        if (last_in && !result_out) begin
            pending_next = pending_reg + 3'd1;
        end else if (!last_in && result_out) begin
            pending_next = pending_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    a_result_needs_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (pending_reg != 3'd0))
        else $error("result without a pending last pair");

    a_pending_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 3'd2)
        else $error("more than two results outstanding");

    a_stall_behind_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while the output is full and stalled");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_is_isomorphic)))
        else $error("result dropped or changed while stalled");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule

bind string_isomorphism_checker sic_checker u_sic_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_last_pair     (s_last_pair),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_is_isomorphic (m_is_isomorphic)
);
// ----------------------------------------------------------------------------

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for string_isomorphism_checker. A queue of character
// pairs (directed strings first, then random strings with injected conflicts,
// length differences and noise) feeds a valid/ready driver with random gaps.
// Each accepted pair updates a local copy of the forward and backward maps.
// Every pair marked last yields an expected verdict that the monitor compares
// with the result channel, under random back-pressure.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        logic [sic_pkg::CHAR_W-1:0] src_char;
        logic [sic_pkg::CHAR_W-1:0] dst_char;
        logic                       src_present;
        logic                       dst_present;
        logic                       last_pair;
    } char_pair_t;

    logic                       aclk            = 1'b0;
    logic                       aresetn         = 1'b0;
    logic                       s_valid         = 1'b0;
    logic                       s_ready;
    logic [sic_pkg::CHAR_W-1:0] s_src_char      = '0;
    logic [sic_pkg::CHAR_W-1:0] s_dst_char      = '0;
    logic                       s_src_present   = 1'b0;
    logic                       s_dst_present   = 1'b0;
    logic                       s_last_pair     = 1'b0;
    logic                       m_valid;
    logic                       m_ready         = 1'b0;
    logic                       m_is_isomorphic;

    char_pair_t        pair_q [$];
    bit                verdict_q [$];

    // Local copy of the mapping tables.
    logic [sic_pkg::CHAR_W-1:0] fwd_map [2**sic_pkg::CHAR_W];
    bit                         fwd_set [2**sic_pkg::CHAR_W];
    logic [sic_pkg::CHAR_W-1:0] bwd_map [2**sic_pkg::CHAR_W];
    bit                         bwd_set [2**sic_pkg::CHAR_W];
    bit                         conflict_seen;

    int unsigned       queued_pairs  = 0;
    int unsigned       pairs_sent    = 0;
    int unsigned       strings_done  = 0;
    int unsigned       iso_count     = 0;
    int unsigned       err_cnt       = 0;
    int unsigned       send_gap      = 0;
    int unsigned       recv_stall    = 0;
    bit                send_quiet    = 1'b0;
    bit                recv_quiet    = 1'b0;

    string_isomorphism_checker u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_src_char      (s_src_char),
        .s_dst_char      (s_dst_char),
        .s_src_present   (s_src_present),
        .s_dst_present   (s_dst_present),
        .s_last_pair     (s_last_pair),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_is_isomorphic (m_is_isomorphic)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("Timeout: %0d strings still awaiting a verdict", verdict_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(99, 0);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(3, 1);
        if (r < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    task automatic report_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    // Update the mapping tables with one accepted pair; a last pair yields
    // the verdict for the whole string and clears the tables.
    task automatic track_mapping(input char_pair_t p);
        int unsigned a;
        int unsigned b;
        a = p.src_char;
        b = p.dst_char;
        if (p.src_present && p.dst_present) begin
            if (a >= sic_pkg::ALPHABET || b >= sic_pkg::ALPHABET) begin
                conflict_seen = 1'b1;
            end else begin
                if (!fwd_set[p.src_char]) begin
                    fwd_set[p.src_char] = 1'b1;
                    fwd_map[p.src_char] = p.dst_char;
                end else if (fwd_map[p.src_char] != p.dst_char) begin
                    conflict_seen = 1'b1;
                end
                if (!bwd_set[p.dst_char]) begin
                    bwd_set[p.dst_char] = 1'b1;
                    bwd_map[p.dst_char] = p.src_char;
                end else if (bwd_map[p.dst_char] != p.src_char) begin
                    conflict_seen = 1'b1;
                end
            end
        end else if (p.src_present != p.dst_present) begin
            conflict_seen = 1'b1;
        end
        if (p.last_pair) begin
            verdict_q.push_back(!conflict_seen);
            fwd_set       = '{default: 1'b0};
            bwd_set       = '{default: 1'b0};
            conflict_seen = 1'b0;
        end
    endtask

    task automatic add_pair(input logic [sic_pkg::CHAR_W-1:0] a,
                            input logic [sic_pkg::CHAR_W-1:0] b,
                            input bit sp, input bit dp, input bit last);
        char_pair_t p;
        p.src_char    = a;
        p.dst_char    = b;
        p.src_present = sp;
        p.dst_present = dp;
        p.last_pair   = last;
        pair_q.push_back(p);
        if (sp || dp || last) queued_pairs++;
    endtask

    // Two strings side by side; the shorter one is padded with absent slots.
    task automatic add_words(input string a, input string b);
        int n;
        int i;
        bit sp;
        bit dp;
        n = (a.len() > b.len()) ? a.len() : b.len();
        if (n == 0) begin
            add_pair(8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b1);
        end
        for (i = 0; i < n; i++) begin
            sp = (i < a.len());
            dp = (i < b.len());
            add_pair(sp ? a[i] : 8'($urandom), dp ? b[i] : 8'($urandom), sp, dp,
                     i == n - 1);
        end
    endtask

    task automatic add_random_strings();
        logic [sic_pkg::CHAR_W-1:0] perm [2**sic_pkg::CHAR_W];
        logic [sic_pkg::CHAR_W-1:0] pool [8];
        logic [sic_pkg::CHAR_W-1:0] tmp;
        logic [sic_pkg::CHAR_W-1:0] sc;
        logic [sic_pkg::CHAR_W-1:0] dc;
        int unsigned       len;
        int unsigned       pool_n;
        int unsigned       flavor;
        int unsigned       extra;
        int unsigned       bad_pos;
        int unsigned       r;
        int unsigned       i;
        int unsigned       j;
        bit                wide;
        bit                blanks;
        bit                blank_end;
        for (i = 0; i < 2**sic_pkg::CHAR_W; i++) begin
            perm[i[sic_pkg::CHAR_W-1:0]] = i[sic_pkg::CHAR_W-1:0];
        end
        for (i = 2**sic_pkg::CHAR_W - 1; i > 0; i--) begin
            j                            = $urandom_range(i, 0);
            tmp                          = perm[i[sic_pkg::CHAR_W-1:0]];
            perm[i[sic_pkg::CHAR_W-1:0]] = perm[j[sic_pkg::CHAR_W-1:0]];
            perm[j[sic_pkg::CHAR_W-1:0]] = tmp;
        end
        r = $urandom_range(99, 0);
        wide = 1'b0;
        if (r < 85) begin
            len = $urandom_range(12, 1);
        end else if (r < 97) begin
            len = $urandom_range(40, 13);
        end else begin
            len  = $urandom_range(300, 100);
            wide = 1'b1;
        end
        pool_n = $urandom_range(8, 1);
        for (i = 0; i < 8; i++) pool[i[2:0]] = 8'($urandom);
        flavor    = $urandom_range(9, 0);
        extra     = (flavor == 6 || flavor == 7) ? $urandom_range(3, 1) : 0;
        bad_pos   = $urandom_range(len - 1, 0);
        blanks    = ($urandom_range(5, 0) == 0);
        blank_end = ($urandom_range(4, 0) == 0);
        for (i = 0; i < len + extra; i++) begin
            if (blanks && $urandom_range(3, 0) == 0) begin
                add_pair(8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b0);
            end
            sc = wide ? 8'($urandom) : pool[3'($urandom_range(pool_n - 1, 0))];
            dc = perm[sc];
            if (flavor == 5 && i == bad_pos) dc = 8'($urandom);
            if (flavor == 8 && i >= bad_pos) dc = pool[0];
            if (flavor == 9) begin
                add_pair(8'($urandom), 8'($urandom), $urandom_range(3, 0) != 0,
                         $urandom_range(3, 0) != 0,
                         !blank_end && i == len + extra - 1);
            end else begin
                add_pair(sc, dc, flavor != 7 || i < len, flavor != 6 || i < len,
                         !blank_end && i == len + extra - 1);
            end
        end
        if (blank_end) add_pair(8'($urandom), 8'($urandom), 1'b0, 1'b0, 1'b1);
    endtask

    // Driver: the next pair goes out once the previous transfer is done and
    // the random gap has run out.
    always @(posedge aclk) begin
        char_pair_t p;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                p.src_char    = s_src_char;
                p.dst_char    = s_dst_char;
                p.src_present = s_src_present;
                p.dst_present = s_dst_present;
                p.last_pair   = s_last_pair;
                track_mapping(p);
                pairs_sent++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pair_q.size() != 0) begin
                    p = pair_q.pop_front();
                    s_valid       <= 1'b1;
                    s_src_char    <= p.src_char;
                    s_dst_char    <= p.dst_char;
                    s_src_present <= p.src_present;
                    s_dst_present <= p.dst_present;
                    s_last_pair   <= p.last_pair;
                    send_gap = pick_gap(send_quiet);
                    if ($urandom_range(49, 0) == 0) send_quiet = !send_quiet;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random back-pressure and the verdict check.
    always @(posedge aclk) begin
        bit want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    report_error($sformatf("verdict %0b with no string pending",
                                           m_is_isomorphic));
                end else begin
                    want = verdict_q.pop_front();
                    strings_done++;
                    if (want) iso_count++;
                    if (m_is_isomorphic !== want) begin
                        report_error($sformatf("string %0d: is_isomorphic expected %0b, got %0b",
                                               strings_done, want, m_is_isomorphic));
                    end
                end
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(2, 0) == 0) recv_stall = pick_gap(recv_quiet);
                if ($urandom_range(99, 0) == 0) recv_quiet = !recv_quiet;
            end
        end
    end

    initial begin
        fwd_set       = '{default: 1'b0};
        bwd_set       = '{default: 1'b0};
        conflict_seen = 1'b0;

        // Directed strings: classic cases, both length mismatches, the empty
        // pair of strings and the byte extremes.
        add_words("egg", "add");
        add_words("foo", "bar");
        add_words("paper", "title");
        add_words("ab", "aa");
        add_words("abc", "ab");
        add_words("ab", "abc");
        add_words("", "");
        add_pair(8'h00, 8'hFF, 1'b1, 1'b1, 1'b0);
        add_pair(8'hFF, 8'h00, 1'b1, 1'b1, 1'b0);
        add_pair(8'h5A, 8'hA5, 1'b0, 1'b0, 1'b0);
        add_pair(8'h00, 8'hFF, 1'b1, 1'b1, 1'b1);
        add_pair(8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);

        while (queued_pairs < 1150) add_random_strings();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pair_q.size() != 0 || s_valid) @(posedge aclk);
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d character pairs over %0d strings; %0d were isomorphic.",
                 pairs_sent, strings_done, iso_count);
        $display("Mismatches found: %0d", err_cnt);
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sic_pkg.sv
rtl/sic_map_ram.sv
rtl/string_isomorphism_checker.sv
rtl/sic_checker.sv
dv/testbench.sv
